// ----- sv/cnm_pkg.sv -----
// shared types and constants for the cosine nearest match core
// used by the core, its port checker and the testbench; no dependencies

package cnm_pkg;

   // default sizes
   localparam int DEF_MAX_ENTRIES    = 1024;
   localparam int DEF_MAX_DIM        = 512;
   localparam int DEF_COMPONENT_BITS = 16;

   // fixed field widths
   localparam int SLOT_W    = 10;
   localparam int ELEM_W    = 9;
   localparam int VALUE_W   = 16;
   localparam int ID_W      = 32;
   localparam int SCORE_W   = 41;
   localparam int DIMS_W    = 10;
   localparam int ACTIVE_W  = 11;

   // stream packing
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 80;
   localparam int REQ_USER_W = 1;
   localparam int RSP_USER_W = 1;

   // register port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = SCORE_W;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THRESHOLD      = 2'd0,
      CSR_DIMS_IN_USE    = 2'd1,
      CSR_ACTIVE_ENTRIES = 2'd2
   } csr_index_type;

   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_QUERY = 1'b1
   } op_type;

   localparam logic signed [SCORE_W-1:0] THRESHOLD_RESET = 41'sd107374182;
   localparam logic [DIMS_W-1:0]         DIMS_RESET      = 10'd512;
   localparam logic [ACTIVE_W-1:0]       ACTIVE_RESET    = 11'd0;

   // -1.0 in q.30
   localparam logic signed [SCORE_W-1:0] MINUS_ONE_Q30 = -(41'sd1 <<< 30);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SEARCH = 3'b010,
      ST_FLUSH  = 3'b100
   } state_type;

   // tag that follows each read through the multiply-accumulate pipe
   typedef struct packed {
      logic vld;
      logic first;
      logic last;
   } tag_type;

endpackage

// ----- sv/cnm_ram.sv -----
// generic single-write, single-read ram with registered read data
// no dependencies

module cnm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 512
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/cosine_nearest_match_core.sv -----
// cosine nearest match core: brute-force max inner product search
// depends on cnm_pkg and cnm_ram
//
// usage
//   req channel: one item per handshake. tuser[0] = operation (0 load, 1 query).
//   a load writes one component of a stored slot and the slot's identity. a query
//   writes one component of the query buffer; the query item whose element is the
//   last dimension in use starts a search over slots 0 .. active_entries-1.
//   rsp channel: one item per completed search: found, best identity, best score.
//   csr channel: register writes (threshold, dims_in_use, active_entries), always
//   ready, to be written only while the core is idle.
// timing
//   loads and non-final query items are taken while the core is idle.
//   after the final query item req_tready stays low while one shared multiply-accumulate
//   walks every component of every active slot, one stored-vector ram read per cycle,
//   through read, multiply, add and compare stages, and until the result is posted.
//   with no active entries the search is skipped and the result has found = 0.
// reset and stalls
//   synchronous reset returns the registers to their defaults and the core to idle;
//   the rams are not cleared. a result waits in the output register while rsp_tready
//   is low; loads are still taken, and a new search holds its result until the
//   previous one has left.

module cosine_nearest_match_core #(
   parameter int MAX_ENTRIES    = cnm_pkg::DEF_MAX_ENTRIES,
   parameter int MAX_DIM        = cnm_pkg::DEF_MAX_DIM,
   parameter int COMPONENT_BITS = cnm_pkg::DEF_COMPONENT_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   // req_tdata: slot[9:0], element[18:10], value[34:19], entry_id[66:35], zero pad
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [cnm_pkg::REQ_DATA_W-1:0]    req_tdata,
   // req_tuser: operation[0]
   input  logic [cnm_pkg::REQ_USER_W-1:0]    req_tuser,
   // rsp_tdata: best_id[31:0], best_score[72:32], zero pad
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [cnm_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // rsp_tuser: found[0]
   output logic [cnm_pkg::RSP_USER_W-1:0]    rsp_tuser,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [cnm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [cnm_pkg::CSR_DATA_W-1:0]    csr_data
);

   import cnm_pkg::*;

   localparam int ENT_AW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int DIM_AW  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int CB      = COMPONENT_BITS;
   localparam int PROD_W  = 2 * CB;
   localparam int ACC_W   = 64;
   localparam int VEC_DEPTH = (2 ** ENT_AW) * (2 ** DIM_AW);
   localparam int ID_DEPTH  = 2 ** ENT_AW;
   localparam int Q_DEPTH   = 2 ** DIM_AW;

   localparam logic signed [ACC_W-1:0] ACC_CLAMP = 64'sd1 <<< 61;
   localparam logic signed [ACC_W-1:0] SAT_HI    = (64'sd1 <<< (SCORE_W - 1)) - 64'sd1;
   localparam logic signed [ACC_W-1:0] SAT_LO    = -(64'sd1 <<< (SCORE_W - 1));

   // request fields
   logic              req_op;
   logic [SLOT_W-1:0] req_slot;
   logic [ELEM_W-1:0] req_element;
   logic [VALUE_W-1:0] req_value;
   logic [ID_W-1:0]   req_entry_id;
   logic signed [CB-1:0] comp;

   assign req_op       = req_tuser[0];
   assign req_slot     = req_tdata[9:0];
   assign req_element  = req_tdata[18:10];
   assign req_value    = req_tdata[34:19];
   assign req_entry_id = req_tdata[66:35];

   generate
      if (CB <= VALUE_W) begin : g_comp_narrow
         assign comp = req_value[CB-1:0];
      end else begin : g_comp_wide
         assign comp = {{(CB - VALUE_W){1'b0}}, req_value};
      end
   endgenerate

   // registers
   logic signed [SCORE_W-1:0] thr_ff;
   logic [DIMS_W-1:0]         dims_ff;
   logic [ACTIVE_W-1:0]       active_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff    <= THRESHOLD_RESET;
         dims_ff   <= DIMS_RESET;
         active_ff <= ACTIVE_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_THRESHOLD:      thr_ff    <= csr_data;
            CSR_DIMS_IN_USE:    dims_ff   <= csr_data[DIMS_W-1:0];
            CSR_ACTIVE_ENTRIES: active_ff <= csr_data[ACTIVE_W-1:0];
            default: ;
         endcase
      end
   end

   // effective sizes
   logic [31:0]       dims_eff;
   logic [31:0]       ent_cnt;
   logic [DIM_AW-1:0] dim_last;
   logic [ENT_AW-1:0] ent_last;

   always_comb begin
      if (dims_ff == '0) begin
         dims_eff = 32'd1;
      end else if (32'(dims_ff) > 32'(MAX_DIM)) begin
         dims_eff = 32'(MAX_DIM);
      end else begin
         dims_eff = 32'(dims_ff);
      end
      if (32'(active_ff) > 32'(MAX_ENTRIES)) begin
         ent_cnt = 32'(MAX_ENTRIES);
      end else begin
         ent_cnt = 32'(active_ff);
      end
      dim_last = DIM_AW'(dims_eff - 32'd1);
      ent_last = ENT_AW'(ent_cnt - 32'd1);
   end

   // sequencer
   state_type         state_ff, state_in;
   logic [ENT_AW-1:0] ent_ff, ent_in;
   logic [DIM_AW-1:0] dim_ff, dim_in;

   logic req_fire, elem_ok, slot_ok, load_wr, query_wr, trigger;
   logic issue, issue_last_dim, pipe_empty, rsp_free, post;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign elem_ok    = 32'(req_element) < 32'(MAX_DIM);
   assign slot_ok    = 32'(req_slot) < 32'(MAX_ENTRIES);
   assign load_wr    = req_fire && (req_op == OP_LOAD) && elem_ok && slot_ok;
   assign query_wr   = req_fire && (req_op == OP_QUERY) && elem_ok;
   assign trigger    = query_wr && (32'(req_element) == dims_eff - 32'd1);

   assign issue          = (state_ff == ST_SEARCH);
   assign issue_last_dim = (dim_ff == dim_last);

   tag_type rd_tag_ff, mul_tag_ff, acc_tag_ff;

   assign pipe_empty = !rd_tag_ff.vld && !mul_tag_ff.vld && !acc_tag_ff.vld;
   assign rsp_free   = !rsp_tvalid || rsp_tready;
   assign post       = (state_ff == ST_FLUSH) && pipe_empty && rsp_free;

   always_comb begin
      state_in = state_ff;
      ent_in   = ent_ff;
      dim_in   = dim_ff;
      case (state_ff)
         ST_IDLE: begin
            ent_in = '0;
            dim_in = '0;
            if (trigger) begin
               state_in = (ent_cnt == 32'd0) ? ST_FLUSH : ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (issue_last_dim) begin
               dim_in = '0;
               if (ent_ff == ent_last) begin
                  state_in = ST_FLUSH;
               end else begin
                  ent_in = ent_ff + ENT_AW'(1);
               end
            end else begin
               dim_in = dim_ff + DIM_AW'(1);
            end
         end
         ST_FLUSH: begin
            if (post) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      ent_ff <= ent_in;
      dim_ff <= dim_in;
   end

   // memories
   logic [ENT_AW-1:0] wr_slot;
   logic [DIM_AW-1:0] wr_elem;
   logic [CB-1:0]     vec_rdata, q_rdata;
   logic [ID_W-1:0]   id_rdata;

   assign wr_slot = ENT_AW'(32'(req_slot));
   assign wr_elem = DIM_AW'(32'(req_element));

   cnm_ram #(.WIDTH(CB), .DEPTH(VEC_DEPTH)) u_vec_ram (
      .clock   (clock),
      .wr_en   (load_wr),
      .wr_addr ({wr_slot, wr_elem}),
      .wr_data (comp),
      .rd_en   (issue),
      .rd_addr ({ent_ff, dim_ff}),
      .rd_data (vec_rdata)
   );

   cnm_ram #(.WIDTH(ID_W), .DEPTH(ID_DEPTH)) u_id_ram (
      .clock   (clock),
      .wr_en   (load_wr),
      .wr_addr (wr_slot),
      .wr_data (req_entry_id),
      .rd_en   (issue),
      .rd_addr (ent_ff),
      .rd_data (id_rdata)
   );

   cnm_ram #(.WIDTH(CB), .DEPTH(Q_DEPTH)) u_query_ram (
      .clock   (clock),
      .wr_en   (query_wr),
      .wr_addr (wr_elem),
      .wr_data (comp),
      .rd_en   (issue),
      .rd_addr (dim_ff),
      .rd_data (q_rdata)
   );

   // multiply-accumulate pipe
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff, acc_in, acc_base;
   logic [ID_W-1:0]          mul_id_ff, acc_id_ff;

   always_comb begin
      if (mul_tag_ff.first) begin
         acc_base = '0;
      end else if (acc_ff > ACC_CLAMP) begin
         acc_base = ACC_CLAMP;
      end else if (acc_ff < -ACC_CLAMP) begin
         acc_base = -ACC_CLAMP;
      end else begin
         acc_base = acc_ff;
      end
      acc_in = acc_base + ACC_W'(prod_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_tag_ff  <= '0;
         mul_tag_ff <= '0;
         acc_tag_ff <= '0;
      end else begin
         rd_tag_ff.vld   <= issue;
         rd_tag_ff.first <= (dim_ff == '0);
         rd_tag_ff.last  <= issue_last_dim;
         mul_tag_ff      <= rd_tag_ff;
         acc_tag_ff      <= mul_tag_ff;
      end
      if (rd_tag_ff.vld) begin
         prod_ff <= $signed(vec_rdata) * $signed(q_rdata);
         if (rd_tag_ff.last) begin
            mul_id_ff <= id_rdata;
         end
      end
      if (mul_tag_ff.vld) begin
         acc_ff <= acc_in;
         if (mul_tag_ff.last) begin
            acc_id_ff <= mul_id_ff;
         end
      end
   end

   // compare stage
   logic signed [SCORE_W-1:0] score_sat;
   logic signed [SCORE_W-1:0] best_ff;
   logic [ID_W-1:0]           best_id_ff;
   logic                      found_ff;
   logic                      better;

   always_comb begin
      if (acc_ff > SAT_HI) begin
         score_sat = SAT_HI[SCORE_W-1:0];
      end else if (acc_ff < SAT_LO) begin
         score_sat = SAT_LO[SCORE_W-1:0];
      end else begin
         score_sat = acc_ff[SCORE_W-1:0];
      end
      better = acc_tag_ff.vld && acc_tag_ff.last && (score_sat > best_ff)
               && (score_sat > thr_ff);
   end

   always_ff @(posedge clock) begin
      if (trigger) begin
         best_ff    <= MINUS_ONE_Q30;
         best_id_ff <= '0;
         found_ff   <= 1'b0;
      end else if (better) begin
         best_ff    <= score_sat;
         best_id_ff <= acc_id_ff;
         found_ff   <= 1'b1;
      end
   end

   // output register
   logic                      rsp_valid_ff;
   logic                      rsp_found_ff;
   logic [ID_W-1:0]           rsp_id_ff;
   logic signed [SCORE_W-1:0] rsp_score_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (post) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (post) begin
         rsp_found_ff <= found_ff;
         rsp_id_ff    <= found_ff ? best_id_ff : '0;
         rsp_score_ff <= found_ff ? best_ff : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_found_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - ID_W - SCORE_W){1'b0}}, rsp_score_ff, rsp_id_ff};

endmodule

// ----- sv/cnm_checker.sv -----
// port-level checks for the cosine nearest match core, bound to the top level
// depends on cnm_pkg and cosine_nearest_match_core

module cnm_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [cnm_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [cnm_pkg::RSP_USER_W-1:0] rsp_tuser
);

   import cnm_pkg::*;

   logic signed [SCORE_W-1:0] score;
   assign score = rsp_tdata[ID_W+SCORE_W-1:ID_W];

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // no match means zero identity and score
   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("result fields not zero without a match");

   // a match must beat -1.0
   a_found_above_minus_one: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> score > MINUS_ONE_Q30)
      else $error("matched score not above -1.0");

   // reset leaves the core idle with no pending result
   a_reset_idle: assert property (@(posedge clock)
      reset |=> req_tready && !rsp_tvalid)
      else $error("core not idle after reset");

endmodule

bind cosine_nearest_match_core cnm_checker u_cnm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ----- dv/tb_cosine_nearest_match_core.sv -----
// self-checking testbench for cosine_nearest_match_core: loads and queries go in on the
// req stream and every search result is checked against a score predictor kept here
// depends on cnm_pkg and the core rtl

`timescale 1ns / 100ps

module tb_cosine_nearest_match_core;
   import cnm_pkg::*;

   localparam int ENTRIES        = DEF_MAX_ENTRIES;
   localparam int DIM            = DEF_MAX_DIM;
   localparam int RANDOM_ITEMS   = 500;
   localparam int DRAIN_CYCLES   = 16;
   localparam int HOLD_CYCLES    = 1500;
   localparam int CYCLE_LIMIT    = 1000000;
   localparam int REPORT_LIMIT   = 10;

   localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};
   localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};

   typedef struct packed {
      op_type                     op;
      logic [SLOT_W-1:0]          slot;
      logic [ELEM_W-1:0]          element;
      logic signed [VALUE_W-1:0]  value;
      logic [ID_W-1:0]            entry_id;
   } match_req_type;

   typedef struct packed {
      logic                       found;
      logic [ID_W-1:0]            best_id;
      logic signed [SCORE_W-1:0]  best_score;
   } match_rsp_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [REQ_DATA_W-1:0]      req_tdata = '0;
   logic [REQ_USER_W-1:0]      req_tuser = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]      rsp_tdata;
   logic [RSP_USER_W-1:0]      rsp_tuser;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_IDX_W-1:0]       csr_index = '0;
   logic [CSR_DATA_W-1:0]      csr_data = '0;

   // predictor state and register copies
   logic signed [VALUE_W-1:0]  stored_comp [0:ENTRIES*DIM-1];
   logic [ID_W-1:0]            stored_id [0:ENTRIES-1];
   logic signed [VALUE_W-1:0]  query_comp [0:DIM-1];
   logic signed [SCORE_W-1:0]  thr_reg = THRESHOLD_RESET;
   logic [DIMS_W-1:0]          dims_reg = DIMS_RESET;
   logic [ACTIVE_W-1:0]        active_reg = ACTIVE_RESET;

   // which entries the stimulus has written so far, so no search reads an empty one
   bit                         comp_written [0:ENTRIES*DIM-1];
   bit                         query_written [0:DIM-1];

   match_req_type              pending_reqs[$];
   match_rsp_type              expected_matches[$];
   match_req_type              cur_req = '0;
   bit                         offering = 1'b0;
   int unsigned                send_gap = 0;
   int unsigned                rsp_stall = 0;
   bit                         no_idle = 1'b0;
   int unsigned                hold_kick = 0;
   int unsigned                hold_seen = 0;
   int unsigned                hold_left = 0;
   int unsigned                cycle_count = 0;

   int unsigned                items_queued = 0;
   int unsigned                loads_taken = 0;
   int unsigned                queries_taken = 0;
   int unsigned                results_seen = 0;
   int unsigned                matches_seen = 0;
   int unsigned                reg_writes = 0;
   int unsigned                errors = 0;

   cosine_nearest_match_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #5 clock = ~clock;

   function automatic int unsigned dims_eff();
      if (dims_reg == 0) return 1;
      if (dims_reg > DIM) return DIM;
      return dims_reg;
   endfunction

   function automatic int unsigned entries_eff();
      if (active_reg > ENTRIES) return ENTRIES;
      return active_reg;
   endfunction

   function automatic int unsigned idle_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 15);
      return $urandom_range(30, 80);
   endfunction

   function automatic logic signed [VALUE_W-1:0] rand_value();
      logic signed [VALUE_W-1:0] v;
      case ($urandom_range(0, 19))
         0: v = {1'b1, {(VALUE_W-1){1'b0}}};
         1: v = {1'b0, {(VALUE_W-1){1'b1}}};
         2: v = '0;
         3: v = '1;
         default: v = VALUE_W'($urandom);
      endcase
      return v;
   endfunction

   function automatic logic signed [SCORE_W-1:0] rand_threshold();
      logic signed [SCORE_W-1:0] t;
      case ($urandom_range(0, 9))
         0: t = SCORE_MIN;
         1: t = SCORE_MAX;
         2: t = '0;
         3: t = MINUS_ONE_Q30;
         4: t = SCORE_W'({$urandom, $urandom});
         default: begin
            t = $signed($urandom);
            t = t >>> $urandom_range(0, 10);
         end
      endcase
      return t;
   endfunction

   // exact q.30 dot product against every active slot, earliest slot wins a tie
   task automatic search_best_match();
      logic signed [63:0] acc;
      logic signed [63:0] best;
      match_rsp_type      res;
      int unsigned        d;
      int unsigned        n;
      d = dims_eff();
      n = entries_eff();
      best = MINUS_ONE_Q30;
      res = '0;
      for (int unsigned s = 0; s < n; s++) begin
         acc = 0;
         for (int unsigned j = 0; j < d; j++)
            acc += stored_comp[s*DIM + j] * query_comp[j];
         if (acc > best && acc > thr_reg) begin
            best = acc;
            res.found = 1'b1;
            res.best_id = stored_id[s];
            res.best_score = acc[SCORE_W-1:0];
         end
      end
      expected_matches = {expected_matches, res};
   endtask

   task automatic update_match_state(match_req_type r);
      if (r.op == OP_LOAD) begin
         stored_comp[int'(r.slot)*DIM + int'(r.element)] = r.value;
         stored_id[r.slot] = r.entry_id;
         loads_taken++;
      end else begin
         query_comp[r.element] = r.value;
         queries_taken++;
         if (int'(r.element) == dims_eff() - 1)
            search_best_match();
      end
   endtask

   task automatic note_error(string what, longint exp_v, longint act_v);
      errors++;
      if (errors <= REPORT_LIMIT)
         $display("mismatch at cycle %0d: %s expected %0d got %0d", cycle_count, what,
                  exp_v, act_v);
   endtask

   task automatic check_match();
      match_rsp_type              want;
      logic                       got_found;
      logic [ID_W-1:0]            got_id;
      logic signed [SCORE_W-1:0]  got_score;
      got_found = rsp_tuser[0];
      got_id = rsp_tdata[ID_W-1:0];
      got_score = rsp_tdata[ID_W+SCORE_W-1:ID_W];
      results_seen++;
      if (got_found) matches_seen++;
      if (expected_matches.size() == 0) begin
         note_error("result with none pending, score", 0, longint'(got_score));
      end else begin
         want = expected_matches.pop_front();
         if (got_found !== want.found)
            note_error("found", longint'(want.found), longint'(got_found));
         if (got_id !== want.best_id)
            note_error("best_id", longint'(want.best_id), longint'(got_id));
         if (got_score !== want.best_score)
            note_error("best_score", longint'(want.best_score), longint'(got_score));
      end
   endtask

   // req side: one item at a time from the pending queue, random gaps between items
   always @(posedge clock) begin
      if (reset) begin
         offering = 1'b0;
         send_gap = 0;
      end else begin
         if (offering && req_tready) begin
            update_match_state(cur_req);
            offering = 1'b0;
         end
         if (!offering) begin
            if (send_gap > 0) begin
               send_gap--;
            end else if (pending_reqs.size() > 0) begin
               cur_req = pending_reqs.pop_front();
               offering = 1'b1;
               send_gap = no_idle ? 0 : idle_len();
            end
         end
      end
      req_tvalid <= offering;
      req_tdata <= {{(REQ_DATA_W-SLOT_W-ELEM_W-VALUE_W-ID_W){1'b0}}, cur_req.entry_id,
                    cur_req.value, cur_req.element, cur_req.slot};
      req_tuser <= cur_req.op;
   end

   // rsp side: check each item, stall at random or for a long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_match();
         if (rsp_stall > 0) rsp_stall--;
         else if (!no_idle && $urandom_range(0, 3) == 0) rsp_stall = idle_len();
      end
      rsp_tready <= (hold_left == 0) && (rsp_stall == 0);
   end

   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_seen <= 0;
      end else if (hold_kick != hold_seen) begin
         hold_left <= HOLD_CYCLES;
         hold_seen <= hold_kick;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still pending", cycle_count,
                  expected_matches.size());
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic wait_for_idle();
      while (pending_reqs.size() != 0 || offering || expected_matches.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_THRESHOLD:      thr_reg = val;
         CSR_DIMS_IN_USE:    dims_reg = val[DIMS_W-1:0];
         CSR_ACTIVE_ENTRIES: active_reg = val[ACTIVE_W-1:0];
         default: ;
      endcase
      reg_writes++;
   endtask

   task automatic set_regs(logic signed [SCORE_W-1:0] thr, int unsigned d_cfg,
                           int unsigned n_cfg);
      write_reg(CSR_THRESHOLD, thr);
      write_reg(CSR_DIMS_IN_USE, CSR_DATA_W'(d_cfg));
      write_reg(CSR_ACTIVE_ENTRIES, CSR_DATA_W'(n_cfg));
   endtask

   task automatic push_load(int unsigned slot, int unsigned el,
                            logic signed [VALUE_W-1:0] v, logic [ID_W-1:0] id);
      match_req_type r;
      r.op = OP_LOAD;
      r.slot = slot[SLOT_W-1:0];
      r.element = el[ELEM_W-1:0];
      r.value = v;
      r.entry_id = id;
      pending_reqs = {pending_reqs, r};
      comp_written[slot*DIM + el] = 1'b1;
      items_queued++;
   endtask

   // slot and id are don't-care on a query, so they carry random bits
   task automatic push_query(int unsigned el, logic signed [VALUE_W-1:0] v);
      match_req_type r;
      r.op = OP_QUERY;
      r.slot = SLOT_W'($urandom);
      r.element = el[ELEM_W-1:0];
      r.value = v;
      r.entry_id = $urandom;
      pending_reqs = {pending_reqs, r};
      query_written[el] = 1'b1;
      items_queued++;
   endtask

   // true when a final query item now would read only written entries
   function automatic bit search_ready();
      int unsigned d;
      int unsigned n;
      d = dims_eff();
      n = entries_eff();
      for (int unsigned j = 0; j + 1 < d; j++)
         if (!query_written[j]) return 1'b0;
      for (int unsigned s = 0; s < n; s++)
         for (int unsigned j = 0; j < d; j++)
            if (!comp_written[s*DIM + j]) return 1'b0;
      return 1'b1;
   endfunction

   // writes that never start a search
   task automatic push_noise();
      int unsigned el;
      if ($urandom_range(0, 1) == 0) begin
         push_load($urandom_range(0, ENTRIES-1), $urandom_range(0, DIM-1), rand_value(),
                   $urandom);
      end else begin
         el = $urandom_range(0, DIM-1);
         if (el == dims_eff() - 1) el = (el + 1) % DIM;
         push_query(el, rand_value());
      end
   endtask

   initial begin
      int unsigned d;
      int unsigned n;
      int unsigned d_cfg;
      int unsigned n_cfg;
      int unsigned r;
      int unsigned tmp;
      int unsigned pick;
      int unsigned rand_start;
      int unsigned elems[$];

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: no active entries, so a completed query finds nothing
      push_query(0, rand_value());
      push_query(DIM-1, 16'sd0);
      wait_for_idle();

      // bounds and ties: exactly -1.0 is rejected, equal scores keep the earliest slot
      set_regs(SCORE_MIN, 2, 4);
      push_load(0, 0, -16'sd32768, 32'h0000_0000);
      push_load(0, 1, -16'sd32768, 32'h0000_0000);
      push_load(1, 0, -16'sd32768, 32'hffff_ffff);
      push_load(1, 1, -16'sd32767, 32'hffff_ffff);
      push_load(2, 0, -16'sd32768, 32'h5a5a_a5a5);
      push_load(2, 1, -16'sd32767, 32'h5a5a_a5a5);
      push_load(3, 0, -16'sd32768, 32'h1234_5678);
      push_load(3, 1, -16'sd32768, 32'h1234_5678);
      push_query(0, 16'sd32767);
      push_query(1, 16'sd1);
      wait_for_idle();
      // score equal to the threshold does not pass
      write_reg(CSR_THRESHOLD, MINUS_ONE_Q30 + 1);
      push_query(1, 16'sd1);
      wait_for_idle();
      write_reg(CSR_THRESHOLD, SCORE_MAX);
      push_query(1, -16'sd32768);
      wait_for_idle();

      // dims above the maximum saturates, so the top element completes the query
      set_regs(SCORE_MIN, 1023, 0);
      push_query(DIM-2, rand_value());
      push_query(DIM-1, rand_value());
      wait_for_idle();

      // large scores: every component at negative full scale
      set_regs(SCORE_MIN, 16, 1);
      for (int unsigned j = 0; j < 16; j++) push_load(0, j, -16'sd32768, 32'hc0de_0001);
      for (int unsigned j = 0; j < 16; j++) push_query(j, -16'sd32768);
      push_query(15, 16'sd32767);
      wait_for_idle();

      // dims 0 counts as one, searched over sixteen slots
      set_regs(SCORE_MIN, 0, 16);
      for (int unsigned s = 0; s < 16; s++) push_load(s, 0, rand_value(), $urandom);
      push_query(0, 16'sd32767);
      push_query(0, -16'sd32768);
      wait_for_idle();
      set_regs(rand_threshold(), 1, 16);
      push_query(0, rand_value());
      wait_for_idle();

      // receiver holds off while back-to-back searches pile up behind it
      set_regs(SCORE_MIN, 2, 3);
      no_idle = 1'b1;
      hold_kick <= hold_kick + 1;
      repeat (12) push_query(1, rand_value());
      wait_for_idle();
      no_idle = 1'b0;

      // random phases: mostly complete load-then-query sequences with random content
      rand_start = items_queued;
      while (items_queued - rand_start < RANDOM_ITEMS) begin
         wait_for_idle();
         r = $urandom_range(0, 99);
         if (r < 10) n_cfg = 0;
         else if (r < 85) n_cfg = $urandom_range(1, 5);
         else if (r < 95) n_cfg = $urandom_range(6, 10);
         else n_cfg = $urandom_range(ENTRIES+1, 2047);
         r = $urandom_range(0, 99);
         if (n_cfg > ENTRIES) d_cfg = $urandom_range(0, 1);
         else if (n_cfg == 0 && r < 30) d_cfg = $urandom_range(0, 1023);
         else if (r < 5) d_cfg = 0;
         else if (r < 10) d_cfg = 1;
         else if (r < 80) d_cfg = $urandom_range(2, 8);
         else d_cfg = $urandom_range(9, 24);
         set_regs(rand_threshold(), d_cfg, n_cfg);
         no_idle = ($urandom_range(0, 4) == 0);
         d = dims_eff();
         n = entries_eff();

         if (n <= 16) begin
            for (int unsigned s = 0; s < n; s++)
               for (int unsigned j = 0; j < d; j++) begin
                  if (!comp_written[s*DIM + j] || $urandom_range(0, 3) == 0)
                     push_load(s, j, rand_value(), $urandom);
                  if ($urandom_range(0, 9) == 0) push_noise();
               end
         end

         // a search on a stale query before the new one is complete
         if ($urandom_range(0, 4) == 0 && search_ready()) push_query(d-1, rand_value());

         elems.delete();
         if (d <= 24) begin
            for (int unsigned j = 0; j + 1 < d; j++)
               if (!query_written[j] || $urandom_range(0, 2) != 0) elems = {elems, j};
         end else begin
            repeat (8) elems = {elems, $urandom_range(0, d-2)};
         end
         for (int i = elems.size() - 1; i > 0; i--) begin
            pick = $urandom_range(0, i);
            tmp = elems[i];
            elems[i] = elems[pick];
            elems[pick] = tmp;
         end
         foreach (elems[i]) begin
            push_query(elems[i], rand_value());
            if ($urandom_range(0, 9) == 0) push_noise();
         end

         repeat ($urandom_range(1, 3)) begin
            if (d > 1 && $urandom_range(0, 1) == 0)
               push_query($urandom_range(0, d-2), rand_value());
            if (search_ready()) push_query(d-1, rand_value());
         end
      end

      wait_for_idle();
      no_idle = 1'b0;
      if (expected_matches.size() != 0) begin
         errors += expected_matches.size();
         $display("%0d expected results never arrived", expected_matches.size());
      end
      $display("covered %0d loads and %0d queries, %0d search results (%0d with a match)",
               loads_taken, queries_taken, results_seen, matches_seen);
      $display("across %0d register writes in %0d cycles, %0d errors", reg_writes,
               cycle_count, errors);
      if (errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
